@@ hw/rtl/ppp_pkg.sv @@
// Shared types and constants for the pinhole point projection block.
// Holds the request/result structs, register codes and status codes.
// No dependencies.
`default_nettype none

package ppp_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_W        = 32;
  localparam int COEF_W         = 32;
  localparam int REG_W          = 64;
  localparam int REG_COUNT      = 6;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_R0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_R0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_R2_C23 = 3'd5;

  localparam logic [REG_W-1:0] RST_R0_C01 = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_R0_C23 = 64'h0;
  localparam logic [REG_W-1:0] RST_R1_C01 = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_R1_C23 = 64'h0;
  localparam logic [REG_W-1:0] RST_R2_C01 = 64'h0;
  localparam logic [REG_W-1:0] RST_R2_C23 = 64'h0000_0000_0001_0000;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_WZERO = 2'd2;

  typedef logic [REG_COUNT-1:0][REG_W-1:0] ppp_cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [COORD_W-1:0] z_in;
    logic                      in_last;
  } ppp_point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] u_out;
    logic signed [COORD_W-1:0] v_out;
    logic signed [COORD_W-1:0] w_out;
    logic [1:0]                status_out;
    logic                      out_last;
  } ppp_result_t;

  // Classification that travels with each point from front to back.
  typedef struct packed {
    logic zero;
    logic last;
  } ppp_tag_t;

endpackage

`default_nettype wire

@@ hw/rtl/ppp_front.sv @@
// Front end: accepts points, forms the matrix-vector product and flags a zero w.
// Depends on ppp_pkg.
`default_nettype none

module ppp_front #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
  parameter int PW        = 2 * ppp_pkg::COEF_W + 2 - FRAC_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire ppp_pkg::ppp_point_t point,
  input  wire ppp_pkg::ppp_cfg_t   cfg,
  output logic                     push,
  output logic signed [PW-1:0]     p0,
  output logic signed [PW-1:0]     p1,
  output logic signed [PW-1:0]     p2,
  output ppp_pkg::ppp_tag_t        tag
);
  import ppp_pkg::*;

  logic signed [COEF_W-1:0]    m [3][4];
  logic signed [COORD_W-1:0]   coord [3];
  logic signed [2*COEF_W-1:0]  prod [3][3];
  logic signed [PW-1:0]        sum [3];
  logic                        valid1;
  logic                        last1;

  assign coord[0] = point.x_in;
  assign coord[1] = point.y_in;
  assign coord[2] = point.z_in;

  for (genvar gr = 0; gr < 3; gr++) begin : g_row
    for (genvar gc = 0; gc < 4; gc++) begin : g_col
      assign m[gr][gc] = cfg[2*gr + gc/2][(gc%2)*COEF_W +: COEF_W];
    end
    for (genvar gc = 0; gc < 3; gc++) begin : g_mul
      always_ff @(posedge clk) begin
        prod[gr][gc] <= m[gr][gc] * coord[gc];
      end
    end
    // Each product drops its extra fraction bits rounding toward minus infinity.
    assign sum[gr] = PW'(m[gr][3]) + PW'(prod[gr][0] >>> FRAC_BITS)
                   + PW'(prod[gr][1] >>> FRAC_BITS) + PW'(prod[gr][2] >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      push   <= 1'b0;
    end else begin
      valid1 <= accept;
      push   <= valid1;
    end
    last1    <= point.in_last;
    p0       <= sum[0];
    p1       <= sum[1];
    p2       <= sum[2];
    tag.last <= last1;
    tag.zero <= (sum[2] == '0);
  end

endmodule

`default_nettype wire

@@ hw/rtl/ppp_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on nothing but its parameter.
`default_nettype none

module ppp_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty,
  output logic              full
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ppp_div.sv @@
// Pipelined restoring divider: (n * 2^FRAC_BITS) / d, one quotient bit per stage.
// Depends on its parameters only.
`default_nettype none

module ppp_div #(
  parameter int PW         = 50,
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic [PW-1:0]       n,
  input  wire logic [PW-1:0]       d,
  output logic [DATA_WIDTH:0]      q,
  output logic                     big
);

  localparam int QW = DATA_WIDTH + 1;
  localparam int NW = PW + FRAC_BITS;
  localparam int CW = NW + QW;

  logic [CW-1:0] num_c;
  logic [CW-1:0] den_c;
  logic [CW-1:0] rem_c;

  logic [PW:0]   rem   [QW+1];
  logic [QW-1:0] lo    [QW+1];
  logic [PW-1:0] den   [QW+1];
  logic [QW-1:0] quo   [QW+1];
  logic          big_s [QW+1];

  assign num_c = CW'(n) << FRAC_BITS;
  assign den_c = CW'(d) << QW;
  assign rem_c = num_c >> QW;

  // Quotients too large for the output range are flagged up front.
  always_ff @(posedge clk) begin
    rem[0]   <= rem_c[PW:0];
    lo[0]    <= num_c[QW-1:0];
    den[0]   <= d;
    quo[0]   <= '0;
    big_s[0] <= (num_c >= den_c);
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [PW:0] t;
    logic        ge;
    assign t  = {rem[k][PW-1:0], lo[k][QW-1-k]};
    assign ge = (t >= {1'b0, den[k]});
    always_ff @(posedge clk) begin
      rem[k+1]   <= ge ? (t - {1'b0, den[k]}) : t;
      quo[k+1]   <= {quo[k][QW-2:0], ge};
      lo[k+1]    <= lo[k];
      den[k+1]   <= den[k];
      big_s[k+1] <= big_s[k];
    end
  end

  assign q   = quo[QW];
  assign big = big_s[QW];

endmodule

`default_nettype wire

@@ hw/rtl/ppp_back.sv @@
// Back end: divides by w with two pipelined dividers, saturates and forms status.
// Depends on ppp_pkg and ppp_div.
`default_nettype none

module ppp_back #(
  parameter int FRAC_BITS  = ppp_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = ppp_pkg::DATA_WIDTH_DEF,
  parameter int PW         = 2 * ppp_pkg::COEF_W + 2 - FRAC_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 valid,
  input  wire logic signed [PW-1:0] p0,
  input  wire logic signed [PW-1:0] p1,
  input  wire logic signed [PW-1:0] p2,
  input  wire ppp_pkg::ppp_tag_t    tag,
  output logic                      done,
  output ppp_pkg::ppp_result_t      result
);
  import ppp_pkg::*;

  localparam int LAT = DATA_WIDTH + 2;
  localparam int QW  = DATA_WIDTH + 1;
  localparam int XW  = ((PW > DATA_WIDTH) ? PW : DATA_WIDTH) + 1;
  localparam logic signed [XW-1:0] SMAX = (XW'(1) <<< (DATA_WIDTH - 1)) - XW'(1);
  localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);
  localparam logic [QW-1:0] QMAXP = (QW'(1) << (DATA_WIDTH - 1)) - QW'(1);
  localparam logic [QW-1:0] QMAXN = QW'(1) << (DATA_WIDTH - 1);

  function automatic logic [DATA_WIDTH:0] sat_quot(input logic [QW-1:0] qv,
                                                  input logic big, input logic neg);
    logic [DATA_WIDTH-1:0] val;
    logic                  flag;
    flag = 1'b0;
    if (neg) begin
      val = DATA_WIDTH'(~qv + 1'b1);
      if (big || (qv > QMAXN)) begin
        val  = DATA_WIDTH'(SMIN);
        flag = 1'b1;
      end
    end else begin
      val = DATA_WIDTH'(qv);
      if (big || (qv > QMAXP)) begin
        val  = DATA_WIDTH'(SMAX);
        flag = 1'b1;
      end
    end
    return {flag, val};
  endfunction

  logic [PW-1:0]             n0;
  logic [PW-1:0]             n1;
  logic [PW-1:0]             n2;
  logic signed [XW-1:0]      p2x;
  logic [QW-1:0]             qu;
  logic [QW-1:0]             qv;
  logic                      bigu;
  logic                      bigv;
  logic [DATA_WIDTH:0]       su;
  logic [DATA_WIDTH:0]       sv;

  logic                         vld_s  [LAT+1];
  logic                         zero_s [LAT+1];
  logic                         last_s [LAT+1];
  logic                         negu_s [LAT+1];
  logic                         negv_s [LAT+1];
  logic                         wflg_s [LAT+1];
  logic signed [DATA_WIDTH-1:0] wval_s [LAT+1];

  assign n0  = p0[PW-1] ? (~p0 + 1'b1) : p0;
  assign n1  = p1[PW-1] ? (~p1 + 1'b1) : p1;
  assign n2  = p2[PW-1] ? (~p2 + 1'b1) : p2;
  assign p2x = XW'(p2);

  assign vld_s[0]  = valid;
  assign zero_s[0] = tag.zero;
  assign last_s[0] = tag.last;
  assign negu_s[0] = p0[PW-1] ^ p2[PW-1];
  assign negv_s[0] = p1[PW-1] ^ p2[PW-1];
  assign wflg_s[0] = (p2x > SMAX) || (p2x < SMIN);
  assign wval_s[0] = (p2x > SMAX) ? DATA_WIDTH'(SMAX) :
                     (p2x < SMIN) ? DATA_WIDTH'(SMIN) : DATA_WIDTH'(p2x);

  ppp_div #(.PW(PW), .FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_div_u (
    .clk(clk), .n(n0), .d(n2), .q(qu), .big(bigu)
  );
  ppp_div #(.PW(PW), .FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_div_v (
    .clk(clk), .n(n1), .d(n2), .q(qv), .big(bigv)
  );

  for (genvar k = 0; k < LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
      zero_s[k+1] <= zero_s[k];
      last_s[k+1] <= last_s[k];
      negu_s[k+1] <= negu_s[k];
      negv_s[k+1] <= negv_s[k];
      wflg_s[k+1] <= wflg_s[k];
      wval_s[k+1] <= wval_s[k];
    end
  end

  assign su = sat_quot(qu, bigu, negu_s[LAT]);
  assign sv = sat_quot(qv, bigv, negv_s[LAT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_s[LAT];
    end
    result.out_last <= last_s[LAT];
    if (zero_s[LAT]) begin
      result.u_out      <= '0;
      result.v_out      <= '0;
      result.w_out      <= '0;
      result.status_out <= STATUS_WZERO;
    end else begin
      result.u_out      <= COORD_W'($signed(su[DATA_WIDTH-1:0]));
      result.v_out      <= COORD_W'($signed(sv[DATA_WIDTH-1:0]));
      result.w_out      <= COORD_W'(wval_s[LAT]);
      result.status_out <= (su[DATA_WIDTH] || sv[DATA_WIDTH] || wflg_s[LAT]) ?
                           STATUS_SAT : STATUS_OK;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pinhole_point_projection.sv @@
// Pinhole point projection: a point passes the front-end product and sum registers,
// the queue, the divider stages and the result register; one point is accepted
// every cycle while busy is low. Most of the pipeline lies in the two dividers,
// which resolve one quotient bit per stage; they take new operands every cycle, so
// nothing limits the rate. The receiver cannot stall, so done pulses exactly
// one cycle per point. Synchronous active-high reset clears all valid state and
// reloads the projection matrix with the identity-like default values.
`default_nettype none

module pinhole_point_projection #(
  parameter int DATA_WIDTH = ppp_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ppp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire ppp_pkg::ppp_point_t            point,
  output logic                                done,
  output ppp_pkg::ppp_result_t                result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ppp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppp_pkg::REG_W-1:0]      cfg_data
);
  import ppp_pkg::*;

  // Width of the unsaturated homogeneous sums p0, p1 and p2.
  localparam int PW = 2 * COEF_W + 2 - FRAC_BITS;
  localparam int QDW = 3 * PW + 2;

  ppp_cfg_t             cfg;
  logic                 accept;
  logic                 push;
  logic signed [PW-1:0] fp0;
  logic signed [PW-1:0] fp1;
  logic signed [PW-1:0] fp2;
  ppp_tag_t             ftag;
  logic [QDW-1:0]       q_din;
  logic [QDW-1:0]       q_dout;
  logic                 q_empty;
  logic                 q_full;
  ppp_tag_t             btag;

  // The configuration channel always takes a request. Unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[REG_R0_C01] <= RST_R0_C01;
      cfg[REG_R0_C23] <= RST_R0_C23;
      cfg[REG_R1_C01] <= RST_R1_C01;
      cfg[REG_R1_C23] <= RST_R1_C23;
      cfg[REG_R2_C01] <= RST_R2_C01;
      cfg[REG_R2_C23] <= RST_R2_C23;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_R0_C01: cfg[REG_R0_C01] <= cfg_data;
        REG_R0_C23: cfg[REG_R0_C23] <= cfg_data;
        REG_R1_C01: cfg[REG_R1_C01] <= cfg_data;
        REG_R1_C23: cfg[REG_R1_C23] <= cfg_data;
        REG_R2_C01: cfg[REG_R2_C01] <= cfg_data;
        REG_R2_C23: cfg[REG_R2_C23] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A request is taken whenever the queue has room; the back end drains the
  // queue every cycle, so busy stays low in normal operation.
  assign busy   = q_full;
  assign accept = start && !busy;

  // The front end multiplies and sums, and marks points whose w is zero.
  ppp_front #(.FRAC_BITS(FRAC_BITS), .PW(PW)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .point(point), .cfg(cfg),
    .push(push), .p0(fp0), .p1(fp1), .p2(fp2), .tag(ftag)
  );

  assign q_din = {ftag, fp2, fp1, fp0};

  ppp_queue #(.W(QDW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .din(q_din), .pop(!q_empty),
    .dout(q_dout), .empty(q_empty), .full(q_full)
  );

  assign btag = q_dout[QDW-1 -: 2];

  // The back end performs both divisions in parallel and saturates the results.
  ppp_back #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH), .PW(PW)) u_back (
    .clk(clk), .rst(rst), .valid(!q_empty),
    .p0(q_dout[PW-1:0]), .p1(q_dout[2*PW-1:PW]), .p2(q_dout[3*PW-1:2*PW]),
    .tag(btag), .done(done), .result(result)
  );

  // The queue is drained every cycle, so it never fills.
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("projection queue filled up");

  // A zero w always yields zero coordinates.
  a_zero_w: assert property (@(posedge clk) disable iff (rst)
    (done && result.status_out == STATUS_WZERO) |->
      (result.u_out == '0 && result.v_out == '0 && result.w_out == '0))
    else $error("zero w produced nonzero outputs");

  // An unsaturated result never carries a zero w.
  a_ok_w: assert property (@(posedge clk) disable iff (rst)
    (done && result.status_out == STATUS_OK) |-> (result.w_out != '0))
    else $error("ok status with zero w");

  // The status code never goes past the zero-w code.
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status_out <= STATUS_WZERO))
    else $error("invalid status code");

endmodule

`default_nettype wire
